// ===== design/obs_pkg.sv =====
// Package for the offset bitmap set: operation codes, word types and defaults.
// Used by obs_step, offset_bitmap_set_core, obs_set_checker and tb_top; depends on nothing else.
`default_nettype none

package obs_pkg;

  // Default size of the presence window in bits.
  localparam int unsigned WindowBitsDefault = 64;

  // Width of the member count field in a result word.
  localparam int unsigned CountW = 7;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] element;
  } in_word_t;

  typedef struct packed {
    logic              ok;
    logic              no_room;
    logic [CountW-1:0] member_count;
    logic              is_empty;
  } out_word_t;

endpackage

`default_nettype wire

// ===== design/offset_bitmap_set_core.sv =====
// Top level of the offset bitmap set: input register, state and result register.
// Depends on obs_pkg and obs_step.
`default_nettype none

// A set of signed 32-bit integers kept as a presence bitmap of WindowBits bits
// placed at a base value, set by the first element ever added and moved down to
// a lower added element when all members still fit. Each input word is an add,
// remove or search and yields exactly one result word with the outcome, the
// member count and an empty flag. An add that neither falls in the window nor
// fits by moving the base down is refused with no_room and leaves the set
// unchanged. The block takes one word per cycle while the result side does not
// stall: a word is registered at acceptance, and once the result register is
// free or draining, a single pass of offset subtract, compare, shift and bit
// update writes both the set state and the result register. The state update
// loop closes in that pass, so the next word may use it. Reset empties the set.
module offset_bitmap_set_core import obs_pkg::*; #(
  parameter int unsigned WindowBits = WindowBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int unsigned IdxW = $clog2(WindowBits);
  localparam int unsigned MemW = $clog2(WindowBits + 1);

  in_word_t              in_q;
  logic                  in_valid_q;
  out_word_t             out_q;
  logic                  out_valid_q;

  logic [WindowBits-1:0] presence_q, presence_d;
  logic [31:0]           base_q, base_d;
  logic [IdxW-1:0]       top_q, top_d;
  logic [MemW-1:0]       members_q, members_d;
  logic                  started_q, started_d;
  out_word_t             result_d;

  logic                  advance;

  // A registered word moves on when the result register is free or draining.
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  obs_step #(
    .WindowBits(WindowBits)
  ) u_step (
    .word_i    (in_q),
    .presence_i(presence_q),
    .base_i    (base_q),
    .top_i     (top_q),
    .members_i (members_q),
    .started_i (started_q),
    .presence_o(presence_d),
    .base_o    (base_d),
    .top_o     (top_d),
    .members_o (members_d),
    .started_o (started_d),
    .result_o  (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presence_q <= '0;
      base_q     <= '0;
      top_q      <= '0;
      members_q  <= '0;
      started_q  <= 1'b0;
    end else if (advance) begin
      presence_q <= presence_d;
      base_q     <= base_d;
      top_q      <= top_d;
      members_q  <= members_d;
      started_q  <= started_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result_d;
    end
  end

  // The member count always matches the bits set in the window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(presence_q) == 32'(members_q))
    else $error("member count disagrees with presence bitmap");

  // No bit is ever set above the highest used offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (presence_q >> top_q) <= WindowBits'(1))
    else $error("presence bit set above top offset");

  // A refused add never reports success, and the empty flag follows the count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!(out_q.ok && out_q.no_room)
                     && (out_q.is_empty == (out_q.member_count == '0))))
    else $error("inconsistent result word");

  // A state change only follows a word passing through the update stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(advance) |-> $stable(members_q) && $stable(base_q))
    else $error("set state changed without an operation");

endmodule

`default_nettype wire

// ===== design/obs_step.sv =====
// Next-state and result logic for one operation of the offset bitmap set.
// Purely combinational; uses obs_pkg for the word types and operation codes.
`default_nettype none

module obs_step import obs_pkg::*; #(
  parameter int unsigned WindowBits = WindowBitsDefault
) (
  input  in_word_t                         word_i,
  input  logic [WindowBits-1:0]            presence_i,
  input  logic [31:0]                      base_i,
  input  logic [$clog2(WindowBits)-1:0]    top_i,
  input  logic [$clog2(WindowBits+1)-1:0]  members_i,
  input  logic                             started_i,
  output logic [WindowBits-1:0]            presence_o,
  output logic [31:0]                      base_o,
  output logic [$clog2(WindowBits)-1:0]    top_o,
  output logic [$clog2(WindowBits+1)-1:0]  members_o,
  output logic                             started_o,
  output out_word_t                        result_o
);

  localparam int unsigned IdxW = $clog2(WindowBits);
  localparam int unsigned MemW = $clog2(WindowBits + 1);

  logic [32:0]           offset;
  logic [32:0]           back_dist;
  logic [33:0]           fit_sum;
  logic                  off_neg;
  logic                  in_window;
  logic                  fits_below;
  logic                  in_range;
  logic [IdxW-1:0]       idx;
  logic [IdxW-1:0]       shift;
  logic                  bit_set;
  logic                  hit;
  logic                  ok;
  logic                  no_room;

  // Offset of the element from the base, exact in 33 bits.
  assign offset     = {word_i.element[31], word_i.element} - {base_i[31], base_i};
  assign off_neg    = offset[32];
  assign back_dist  = 33'd0 - offset;
  assign in_window  = !off_neg && (offset < 33'(WindowBits));
  assign fit_sum    = {1'b0, back_dist} + 34'(top_i);
  assign fits_below = fit_sum < 34'(WindowBits);
  assign in_range   = !off_neg && (offset <= 33'(top_i));
  assign idx        = offset[IdxW-1:0];
  assign shift      = back_dist[IdxW-1:0];
  assign bit_set    = presence_i[idx];
  assign hit        = started_i && in_range && bit_set;

  always_comb begin
    presence_o = presence_i;
    base_o     = base_i;
    top_o      = top_i;
    members_o  = members_i;
    started_o  = started_i;
    ok         = 1'b0;
    no_room    = 1'b0;
    case (word_i.operation)
      OP_ADD: begin
        if (!started_i) begin
          // The first element ever added becomes the base.
          presence_o = WindowBits'(1);
          base_o     = word_i.element;
          top_o      = '0;
          members_o  = MemW'(1);
          started_o  = 1'b1;
          ok         = 1'b1;
        end else if (in_window) begin
          if (!bit_set) begin
            presence_o      = presence_i;
            presence_o[idx] = 1'b1;
            members_o       = members_i + MemW'(1);
            if (idx > top_i) begin
              top_o = idx;
            end
            ok = 1'b1;
          end
        end else if (off_neg && fits_below) begin
          // Below the base: shift the bitmap up and rebase on this element.
          presence_o = (presence_i << shift) | WindowBits'(1);
          members_o  = members_i + MemW'(1);
          top_o      = top_i + shift;
          base_o     = word_i.element;
          ok         = 1'b1;
        end else begin
          no_room = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          presence_o      = presence_i;
          presence_o[idx] = 1'b0;
          members_o       = members_i - MemW'(1);
          ok              = 1'b1;
        end
      end
      OP_SEARCH: begin
        ok = hit;
      end
      default: begin
      end
    endcase
  end

  assign result_o.ok           = ok;
  assign result_o.no_room      = no_room;
  assign result_o.member_count = CountW'(members_o);
  assign result_o.is_empty     = (members_o == '0);

endmodule

`default_nettype wire

// ===== verif/obs_set_checker.sv =====
// Checker for offset_bitmap_set_core: watches both channels, predicts each result
// word from its own copy of the set state, and compares in order.
// Depends on obs_pkg.
module obs_set_checker import obs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_word_t  in_word_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_word_t out_word_i,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint WinSize = longint'(WindowBitsDefault);

  typedef struct {
    in_word_t  cause;
    out_word_t want;
  } awaited_t;

  awaited_t awaited_words[$];

  // Model of the set state.
  logic [WindowBitsDefault-1:0] presence_q;
  logic signed [31:0]           base_q;
  int                           top_q;
  int                           count_q;
  logic                         started_q;
  int                           fails;

  assign fail_count_o = fails;
  assign pending_o    = awaited_words.size();

  function automatic out_word_t apply_set_op(input in_word_t w);
    longint    off;
    longint    d;
    out_word_t r;
    r   = '0;
    off = longint'(w.element) - longint'(base_q);
    case (w.operation)
      OP_ADD: begin
        if (!started_q) begin
          presence_q = '0;
          presence_q[0] = 1'b1;
          base_q    = w.element;
          top_q     = 0;
          count_q   = 1;
          started_q = 1'b1;
          r.ok      = 1'b1;
        end else if (off >= 0 && off < WinSize) begin
          if (!presence_q[off]) begin
            presence_q[off] = 1'b1;
            count_q++;
            if (off > top_q) top_q = int'(off);
            r.ok = 1'b1;
          end
        end else if (off < 0) begin
          // Rebase only when every used offset still fits after the shift.
          d = -off;
          if (longint'(top_q) + d < WinSize) begin
            presence_q = (presence_q << d) | 1;
            count_q++;
            top_q  = top_q + int'(d);
            base_q = w.element;
            r.ok   = 1'b1;
          end else begin
            r.no_room = 1'b1;
          end
        end else begin
          r.no_room = 1'b1;
        end
      end
      OP_REMOVE, OP_SEARCH: begin
        if (started_q && off >= 0 && off <= top_q && presence_q[off]) begin
          r.ok = 1'b1;
          if (w.operation == OP_REMOVE) begin
            presence_q[off] = 1'b0;
            count_q--;
          end
        end
      end
      default: begin
      end
    endcase
    r.member_count = count_q[CountW-1:0];
    r.is_empty     = (count_q == 0);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    awaited_t head;
    if (!rst_ni) begin
      presence_q = '0;
      base_q     = '0;
      top_q      = 0;
      count_q    = 0;
      started_q  = 1'b0;
      fails      = 0;
      awaited_words.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_words.size() == 0) begin
          if (fails < 10) begin
            $display("%0t: result word with nothing expected: ok=%0b no_room=%0b count=%0d",
                     $realtime, out_word_i.ok, out_word_i.no_room,
                     out_word_i.member_count);
          end
          fails = fails + 1;
        end else begin
          head = awaited_words.pop_front();
          if (out_word_i.ok !== head.want.ok || out_word_i.no_room !== head.want.no_room ||
              out_word_i.member_count !== head.want.member_count ||
              out_word_i.is_empty !== head.want.is_empty) begin
            if (fails < 10) begin
              $display("%0t: op %0d element %0d: expected ok=%0b no_room=%0b count=%0d empty=%0b",
                       $realtime, head.cause.operation, head.cause.element, head.want.ok,
                       head.want.no_room, head.want.member_count, head.want.is_empty);
              $display("%0t:   got ok=%0b no_room=%0b count=%0d empty=%0b", $realtime,
                       out_word_i.ok, out_word_i.no_room, out_word_i.member_count,
                       out_word_i.is_empty);
            end
            fails = fails + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        head.cause = in_word_i;
        head.want  = apply_set_op(in_word_i);
        awaited_words.push_back(head);
      end
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Top of the offset bitmap set testbench: clock, reset, stimulus and verdict.
// Depends on obs_pkg, offset_bitmap_set_core and obs_set_checker.
module tb_top;
  import obs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OpUnused = 2'd3;
  // Base of the set once the directed words have run; random values cluster here.
  localparam int BaseAfterSetup = 47;
  localparam int RandomWords    = 1250;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;
  int        fail_count;
  int        pending;

  int   send_idle_pct;
  int   recv_idle_pct;
  int   add_pct;
  logic hold_req;
  logic hold_done;

  offset_bitmap_set_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word)
  );

  obs_set_checker checker_inst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_word_i  (out_word),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off that backs the block up.
  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        out_ready = 1'b0;
        repeat (300) @(negedge clk_i);
        hold_done = 1'b1;
      end
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Called at a falling edge; returns at a falling edge after the word is taken and any random idle time.
  task automatic offer_word(input logic [1:0] op, input logic signed [31:0] value);
    in_word.operation = op;
    in_word.element   = value;
    in_valid          = 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
  endtask

  function automatic logic signed [31:0] pick_element();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return $urandom;
    if (sel < 15) return BaseAfterSetup - 8 + $urandom_range(7);
    return BaseAfterSetup + $urandom_range(66);
  endfunction

  function automatic logic [1:0] pick_operation();
    int sel;
    sel = $urandom_range(99);
    if (sel < add_pct) return OP_ADD;
    if (sel < add_pct + (95 - add_pct) / 2) return OP_REMOVE;
    if (sel < 95) return OP_SEARCH;
    return OpUnused;
  endfunction

  initial begin
    int guard;
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    in_word       = '0;
    send_idle_pct = 28;
    recv_idle_pct = 61;
    add_pct       = 45;
    hold_req      = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Lookups on a set that has never seen an add.
    offer_word(OP_SEARCH, 0);
    offer_word(OP_REMOVE, 5);
    // The first add fixes the base; then duplicates, growth and rebasing.
    offer_word(OP_ADD, 100);
    offer_word(OP_ADD, 100);
    offer_word(OP_ADD, 110);
    offer_word(OP_ADD, 90);
    offer_word(OP_ADD, 43);
    offer_word(OP_ADD, 47);
    offer_word(OP_ADD, 111);
    offer_word(OP_ADD, 110);
    offer_word(OP_SEARCH, 47);
    offer_word(OP_SEARCH, 110);
    offer_word(OP_SEARCH, 46);
    offer_word(OP_SEARCH, 111);
    offer_word(OP_REMOVE, 90);
    offer_word(OP_SEARCH, 90);
    // Extreme values lie far outside the window.
    offer_word(OP_ADD, 32'sh8000_0000);
    offer_word(OP_ADD, 32'sh7fff_ffff);
    offer_word(OP_SEARCH, 32'sh8000_0000);
    offer_word(OpUnused, 32'shffff_ffff);
    // Drain the set, then add again relative to the kept base.
    offer_word(OP_REMOVE, 47);
    offer_word(OP_REMOVE, 100);
    offer_word(OP_REMOVE, 110);
    offer_word(OP_REMOVE, 110);
    offer_word(OP_ADD, 60);

    for (int n = 0; n < RandomWords; n++) begin
      if (n == RandomWords / 3) begin
        send_idle_pct = 61;
        recv_idle_pct = 28;
        add_pct       = 75;
      end else if (n == 2 * RandomWords / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_pct       = 45;
        hold_req      = 1'b1;
      end
      offer_word(pick_operation(), pick_element());
    end
    in_valid = 1'b0;

    guard = 0;
    while (pending != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
